@@ rtl/pti_pkg.sv @@
// Shared types and constants for the partial trapezoid integral unit.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package pti_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int INDEX_W         = 6;
    localparam int COUNT_W         = 7;
    localparam int STATUS_W        = 2;

    // Round half up before dropping the 17 fraction bits of the sum.
    localparam int ROUND_HALF = 65536;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_BELOW = 2'd1,
        STATUS_SAT   = 2'd2
    } status_code_t;

    // What a memory read issued by the controller is for.
    typedef enum logic [1:0] {
        RD_FIRST = 2'd0,
        RD_LAST  = 2'd1,
        RD_SCAN  = 2'd2,
        RD_HALF  = 2'd3
    } rd_kind_t;

    typedef struct packed {
        logic     start;
        logic     load_wr;
        logic     rd_en;
        rd_kind_t kind;
        logic     in_range;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic pipe_empty;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/pti_datapath.sv @@
// Datapath of the partial trapezoid integral unit: entry memories, interval
// scan, shared multiplier, wide accumulator and output register. Uses pti_pkg.
module pti_datapath #(
    parameter int MAX_ENTRIES = pti_pkg::MAX_ENTRIES_DEF,
    parameter int AW          = $clog2(MAX_ENTRIES)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pti_pkg::cmd_t                      cmd,
    output pti_pkg::sts_t                      sts,
    output logic [AW-1:0]                      m_idx,
    input  logic [AW-1:0]                      node_addr,
    input  logic [AW-1:0]                      wv_addr,
    input  logic [pti_pkg::INDEX_W-1:0]        entry_index,
    input  logic signed [pti_pkg::DATA_W-1:0]  node_position,
    input  logic signed [pti_pkg::DATA_W-1:0]  node_weight,
    input  logic signed [pti_pkg::DATA_W-1:0]  sample_value,
    input  logic signed [pti_pkg::DATA_W-1:0]  query_point,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pti_pkg::DATA_W-1:0]  integral_out,
    output logic [pti_pkg::STATUS_W-1:0]       status
);

    localparam int DW    = pti_pkg::DATA_W;
    localparam int XW    = (AW > pti_pkg::INDEX_W) ? AW : pti_pkg::INDEX_W;
    localparam int ACC_W = 67 + $clog2(MAX_ENTRIES);
    localparam logic signed [ACC_W-1:0] LIM_POS = {{(ACC_W-49){1'b0}}, 1'b1, 48'd0};
    localparam logic signed [ACC_W-1:0] LIM_NEG = -LIM_POS;

    logic [DW-1:0] node_mem   [MAX_ENTRIES];
    logic [DW-1:0] weight_mem [MAX_ENTRIES];
    logic [DW-1:0] value_mem  [MAX_ENTRIES];

    logic [XW-1:0] idx_ext;
    logic [AW-1:0] wr_addr;
    logic          wr_ok;

    logic signed [DW-1:0] node_rd_reg;
    logic signed [DW-1:0] w_rd_reg;
    logic signed [DW-1:0] v_rd_reg;
    logic signed [DW-1:0] y_reg;

    logic              s1_v_reg;
    pti_pkg::rd_kind_t s1_kind_reg;
    logic              s1_in_range_reg;

    logic s2_add_reg, s2_add_next;
    logic s2_dbl_reg, s2_dbl_next;
    logic signed [DW:0]   a_reg, a_next;
    logic signed [DW-1:0] b_reg;

    logic                   s3_add_reg;
    logic                   s3_dbl_reg;
    logic signed [2*DW:0]   prod_reg;
    logic signed [2*DW+1:0] term;

    logic signed [ACC_W-1:0] acc_reg;
    logic                    below_reg, below_next;
    logic                    full_reg, full_next;
    logic                    run_reg, run_next;
    logic [AW-1:0]           m_reg, m_next;

    logic                   ge;
    logic signed [DW:0]     diff;

    logic                      out_valid_reg;
    logic signed [DW-1:0]      integral_reg, integral_next;
    pti_pkg::status_code_t     status_reg, status_next;

    assign idx_ext = XW'(entry_index);
    assign wr_addr = idx_ext[AW-1:0];
    assign wr_ok   = (32'(entry_index) < 32'(MAX_ENTRIES));

    // Entry memories: one write port for loads, one registered read port each.
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && wr_ok)
        begin
            node_mem[wr_addr]   <= node_position;
            weight_mem[wr_addr] <= node_weight;
            value_mem[wr_addr]  <= sample_value;
        end
        if (cmd.rd_en)
        begin
            node_rd_reg <= node_mem[node_addr];
            w_rd_reg    <= weight_mem[wv_addr];
            v_rd_reg    <= value_mem[wv_addr];
        end
    end

    assign ge   = (y_reg >= node_rd_reg);
    assign diff = $signed({y_reg[DW-1], y_reg}) - $signed({node_rd_reg[DW-1], node_rd_reg});

    // Read-data stage: interval decisions and multiplier operand selection.
    always_comb
    begin
        below_next  = below_reg;
        full_next   = full_reg;
        run_next    = run_reg;
        m_next      = m_reg;
        s2_add_next = 1'b0;
        s2_dbl_next = 1'b0;
        a_next      = {w_rd_reg[DW-1], w_rd_reg};
        if (cmd.start)
        begin
            below_next = 1'b0;
            full_next  = 1'b0;
            run_next   = 1'b1;
            m_next     = '0;
        end
        else if (s1_v_reg)
        begin
            case (s1_kind_reg)
                pti_pkg::RD_FIRST:
                begin
                    below_next = (y_reg < node_rd_reg);
                end
                pti_pkg::RD_LAST:
                begin
                    full_next = (node_rd_reg <= y_reg);
                end
                pti_pkg::RD_SCAN:
                begin
                    s2_dbl_next = 1'b1;
                    if (full_reg)
                    begin
                        s2_add_next = 1'b1;
                    end
                    else if (s1_in_range_reg)
                    begin
                        if (run_reg && ge)
                        begin
                            s2_add_next = 1'b1;
                            m_next      = m_reg + AW'(1);
                        end
                        else
                        begin
                            run_next = 1'b0;
                        end
                    end
                end
                pti_pkg::RD_HALF:
                begin
                    s2_add_next = 1'b1;
                    a_next      = diff;
                end
                default:
                begin
                    s2_add_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            s2_add_reg <= 1'b0;
            s3_add_reg <= 1'b0;
            below_reg  <= 1'b0;
            full_reg   <= 1'b0;
            run_reg    <= 1'b0;
            m_reg      <= '0;
        end
        else
        begin
            s1_v_reg   <= cmd.rd_en;
            s2_add_reg <= s2_add_next;
            s3_add_reg <= s2_add_reg;
            below_reg  <= below_next;
            full_reg   <= full_next;
            run_reg    <= run_next;
            m_reg      <= m_next;
        end
    end

    // Payload pipeline: operands, product, then accumulation.
    always_ff @(posedge clk)
    begin
        s1_kind_reg     <= cmd.kind;
        s1_in_range_reg <= cmd.in_range;
        a_reg           <= a_next;
        b_reg           <= v_rd_reg;
        s2_dbl_reg      <= s2_dbl_next;
        prod_reg        <= a_reg * b_reg;
        s3_dbl_reg      <= s2_dbl_reg;
        if (cmd.start)
        begin
            y_reg   <= query_point;
            acc_reg <= ACC_W'(pti_pkg::ROUND_HALF);
        end
        else if (s3_add_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W-2*DW-2){term[2*DW+1]}}, term};
        end
    end

    // A stored weight is Q16.16 and counts twice against the Q16.17 half weights.
    assign term = s3_dbl_reg ? {prod_reg, 1'b0} : {prod_reg[2*DW], prod_reg};

    always_comb
    begin
        if (below_reg)
        begin
            integral_next = '0;
            status_next   = pti_pkg::STATUS_BELOW;
        end
        else if (acc_reg >= LIM_POS)
        begin
            integral_next = pti_pkg::SAT_MAX;
            status_next   = pti_pkg::STATUS_SAT;
        end
        else if (acc_reg < LIM_NEG)
        begin
            integral_next = pti_pkg::SAT_MIN;
            status_next   = pti_pkg::STATUS_SAT;
        end
        else
        begin
            integral_next = acc_reg[48:17];
            status_next   = pti_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            integral_reg <= integral_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign integral_out   = integral_reg;
    assign status         = status_reg;
    assign m_idx          = m_reg;
    assign sts.full       = full_reg;
    assign sts.pipe_empty = !s1_v_reg && !s2_add_reg && !s3_add_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

endmodule

@@ rtl/pti_ctrl.sv @@
// Controller of the partial trapezoid integral unit: entry count register,
// query sequencer and memory read addresses. Uses pti_pkg.
module pti_ctrl #(
    parameter int MAX_ENTRIES = pti_pkg::MAX_ENTRIES_DEF,
    parameter int AW          = $clog2(MAX_ENTRIES)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pti_pkg::COUNT_W-1:0]  cfg_data,
    output pti_pkg::cmd_t                cmd,
    input  pti_pkg::sts_t                sts,
    input  logic [AW-1:0]                m_idx,
    output logic [AW-1:0]                node_addr,
    output logic [AW-1:0]                wv_addr
);

    localparam int NW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_RD_FIRST = 8'b0000_0010,
        ST_RD_LAST = 8'b0000_0100,
        ST_SWEEP   = 8'b0000_1000,
        ST_SETTLE  = 8'b0001_0000,
        ST_HALF_LO = 8'b0010_0000,
        ST_HALF_HI = 8'b0100_0000,
        ST_DRAIN   = 8'b1000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] k_reg, k_next;
    logic [NW-1:0] km1;
    logic [NW-1:0] nm1;

    assign km1 = k_reg - NW'(1);
    assign nm1 = n_reg - NW'(1);

    // The count register holds the clamped entry count.
    always_comb
    begin
        n_next = n_reg;
        if (cfg_valid)
        begin
            if (cfg_data < pti_pkg::COUNT_W'(2))
            begin
                n_next = NW'(2);
            end
            else if (32'(cfg_data) > 32'(MAX_ENTRIES))
            begin
                n_next = NW'(MAX_ENTRIES);
            end
            else
            begin
                n_next = NW'(cfg_data);
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        cmd          = '0;
        cmd.kind     = pti_pkg::RD_FIRST;
        node_addr    = '0;
        wv_addr      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == pti_pkg::OP_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_RD_FIRST;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            ST_RD_FIRST:
            begin
                cmd.rd_en  = 1'b1;
                cmd.kind   = pti_pkg::RD_FIRST;
                state_next = ST_RD_LAST;
            end
            ST_RD_LAST:
            begin
                cmd.rd_en  = 1'b1;
                cmd.kind   = pti_pkg::RD_LAST;
                node_addr  = nm1[AW-1:0];
                k_next     = NW'(1);
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                cmd.rd_en    = 1'b1;
                cmd.kind     = pti_pkg::RD_SCAN;
                cmd.in_range = (k_reg <= n_reg - NW'(2));
                node_addr    = k_reg[AW-1:0];
                wv_addr      = km1[AW-1:0];
                if (k_reg == n_reg)
                begin
                    state_next = ST_SETTLE;
                end
                else
                begin
                    k_next = k_reg + NW'(1);
                end
            end
            ST_SETTLE:
            begin
                state_next = sts.full ? ST_DRAIN : ST_HALF_LO;
            end
            ST_HALF_LO:
            begin
                cmd.rd_en  = 1'b1;
                cmd.kind   = pti_pkg::RD_HALF;
                node_addr  = (m_idx == '0) ? '0 : m_idx - AW'(1);
                wv_addr    = m_idx;
                state_next = ST_HALF_HI;
            end
            ST_HALF_HI:
            begin
                cmd.rd_en  = 1'b1;
                cmd.kind   = pti_pkg::RD_HALF;
                node_addr  = m_idx;
                wv_addr    = m_idx + AW'(1);
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (sts.pipe_empty && sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= NW'(2);
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    a_query_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == pti_pkg::OP_QUERY) |=> !in_ready)
        else $error("input still ready after a query transaction");

    a_no_half_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en && cmd.kind == pti_pkg::RD_HALF) |-> !sts.full)
        else $error("half-weight read issued with the query point past the last node");

    a_sweep_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (k_reg != '0 && k_reg <= n_reg))
        else $error("sweep counter outside the entries in use");

    a_interval_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HALF_LO) |-> (NW'(m_idx) <= n_reg - NW'(2)))
        else $error("interval index beyond the second-last entry");

endmodule

@@ rtl/partial_trapezoid_integral_unit.sv @@
// Partial trapezoid integral unit, top level; needs pti_pkg, pti_ctrl, pti_datapath.
// A load transaction is taken in the idle state and the next item may follow at once.
// A query with n entries in use runs a sweep of one memory read and multiply-accumulate
// per entry (the half-weight reads are skipped when the query point lies at or past the
// last node); the next item is taken once its result is in the output register.
// Reset clears control state and sets the entry count to 2; the stores stay undefined.
module partial_trapezoid_integral_unit #(
    parameter int MAX_ENTRIES = pti_pkg::MAX_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Item channel: loads and queries share it, selected by opcode.
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic [pti_pkg::INDEX_W-1:0]        entry_index,
    input  logic signed [pti_pkg::DATA_W-1:0]  node_position,
    input  logic signed [pti_pkg::DATA_W-1:0]  node_weight,
    input  logic signed [pti_pkg::DATA_W-1:0]  sample_value,
    input  logic signed [pti_pkg::DATA_W-1:0]  query_point,
    // Result channel: one transaction per query, none per load.
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pti_pkg::DATA_W-1:0]  integral_out,
    output logic [pti_pkg::STATUS_W-1:0]       status,
    // Entry count register write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pti_pkg::COUNT_W-1:0]        cfg_data
);

    localparam int AW = $clog2(MAX_ENTRIES);

    // The controller walks a query through its phases: a read of the first
    // node (below-range test), a read of the last node (whole-range test), a
    // sweep over every entry in use, and, unless the query point lies at or past
    // the last node, two half-weight reads around the interval found. The datapath
    // carries each read through a registered memory port, a multiplier stage and a
    // wide accumulator, and decides the interval itself as the sweep data comes back.
    pti_pkg::cmd_t cmd;
    pti_pkg::sts_t sts;
    logic [AW-1:0] m_idx;
    logic [AW-1:0] node_addr;
    logic [AW-1:0] wv_addr;

    pti_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_idx     (m_idx),
        .node_addr (node_addr),
        .wv_addr   (wv_addr)
    );

    // The result sits in the datapath's output register, so a finished
    // query may wait there while the next loads are already taken.
    pti_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .m_idx         (m_idx),
        .node_addr     (node_addr),
        .wv_addr       (wv_addr),
        .entry_index   (entry_index),
        .node_position (node_position),
        .node_weight   (node_weight),
        .sample_value  (sample_value),
        .query_point   (query_point),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .integral_out  (integral_out),
        .status        (status)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for partial_trapezoid_integral_unit: node tables, queries, count sweep.
// Depends on pti_pkg and the unit's RTL; holds its own predictor of the integral and status.

module testbench;

    // This idle stretch covers any work still in flight after the last result.
    localparam int     SETTLE_CYCLES       = 80;
    localparam int     ENTRIES             = pti_pkg::MAX_ENTRIES_DEF;
    localparam int     DW                  = pti_pkg::DATA_W;
    localparam int     LONG_HOLD           = 400;
    localparam int     SEGMENTS            = 10;
    localparam int     QUERIES_PER_SEGMENT = 45;
    localparam longint NODE_MIN            = -64'sd2147483648;
    localparam longint NODE_MAX            = 64'sd2147483647;

    // Wide enough to hold 64 exact Q32.33 products without any chance of overflow.
    typedef logic signed [127:0] wide_t;

    localparam wide_t SUM_LIMIT = 128'sd1 <<< 48;

    typedef struct {
        logic signed [DW-1:0]  integral;
        pti_pkg::status_code_t code;
    } integral_result_t;

    // The scoreboard mirrors the three entry stores and the entry count, works out the
    // integral for every accepted query and checks results against them in order.
    class integral_scoreboard;
        logic [pti_pkg::COUNT_W-1:0] entry_count;
        logic signed [DW-1:0]        node_mem [ENTRIES];
        logic signed [DW-1:0]        weight_mem [ENTRIES];
        logic signed [DW-1:0]        value_mem [ENTRIES];
        integral_result_t            pending_integrals [$];
        int                          failures;
        int                          loads;
        int                          queries;
        int                          count_writes;
        int                          status_tally [3];

        function new();
            entry_count  = pti_pkg::COUNT_W'(2);
            failures     = 0;
            loads        = 0;
            queries      = 0;
            count_writes = 0;
            foreach (status_tally[k])
                status_tally[k] = 0;
        endfunction

        function void set_entry_count(logic [pti_pkg::COUNT_W-1:0] value);
            entry_count = value;
            count_writes++;
        endfunction

        function wide_t widen(logic signed [DW-1:0] x);
            return x;
        endfunction

        function integral_result_t integrate_to(logic signed [DW-1:0] y);
            integral_result_t res;
            int               n;
            int               m;
            wide_t            acc;
            wide_t            wy;
            if (entry_count < 2)
                n = 2;
            else if (entry_count > ENTRIES)
                n = ENTRIES;
            else
                n = int'(entry_count);
            if (y < node_mem[0])
            begin
                res.integral = '0;
                res.code     = pti_pkg::STATUS_BELOW;
                return res;
            end
            acc = 0;
            wy  = y;
            if (node_mem[n-1] <= y)
            begin
                for (int i = 0; i < n; i++)
                    acc += 2 * widen(weight_mem[i]) * widen(value_mem[i]);
            end
            else
            begin
                // The scan stops at the first node above y and never passes entry n-2.
                m = 0;
                while (m < n - 2 && y >= node_mem[m+1])
                    m++;
                for (int i = 0; i < m; i++)
                    acc += 2 * widen(weight_mem[i]) * widen(value_mem[i]);
                // Half-interval weights are exact Q16.17 differences.
                acc += (wy - widen(node_mem[(m > 0) ? m - 1 : 0])) * widen(value_mem[m]);
                acc += (wy - widen(node_mem[m])) * widen(value_mem[m+1]);
            end
            acc += pti_pkg::ROUND_HALF;
            if (acc >= SUM_LIMIT)
            begin
                res.integral = pti_pkg::SAT_MAX;
                res.code     = pti_pkg::STATUS_SAT;
            end
            else if (acc < -SUM_LIMIT)
            begin
                res.integral = pti_pkg::SAT_MIN;
                res.code     = pti_pkg::STATUS_SAT;
            end
            else
            begin
                res.integral = acc[DW+16:17];
                res.code     = pti_pkg::STATUS_OK;
            end
            return res;
        endfunction

        function void note_item(logic op, logic [pti_pkg::INDEX_W-1:0] index,
                                logic signed [DW-1:0] node, weight, value, y);
            if (op == pti_pkg::OP_LOAD)
            begin
                if (int'(index) < ENTRIES)
                begin
                    node_mem[index]   = node;
                    weight_mem[index] = weight;
                    value_mem[index]  = value;
                end
                loads++;
            end
            else
            begin
                pending_integrals.push_back(integrate_to(y));
                queries++;
            end
        endfunction

        function void check_result(logic signed [DW-1:0] integral,
                                   logic [pti_pkg::STATUS_W-1:0] code);
            integral_result_t want;
            if (pending_integrals.size() == 0)
            begin
                $error("result %0d with status %0d arrived with no query outstanding",
                       integral, code);
                failures++;
                return;
            end
            want = pending_integrals.pop_front();
            if (integral !== want.integral)
            begin
                $error("integral_out: expected %0d, actual %0d", want.integral, integral);
                failures++;
            end
            if (code !== want.code)
            begin
                $error("status: expected %0d, actual %0d", want.code, code);
                failures++;
            end
            status_tally[want.code]++;
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic                                opcode;
    logic [pti_pkg::INDEX_W-1:0]         entry_index;
    logic signed [DW-1:0]                node_position;
    logic signed [DW-1:0]                node_weight;
    logic signed [DW-1:0]                sample_value;
    logic signed [DW-1:0]                query_point;
    logic                                out_valid;
    logic                                out_ready;
    logic signed [DW-1:0]                integral_out;
    logic [pti_pkg::STATUS_W-1:0]        status;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [pti_pkg::COUNT_W-1:0]         cfg_data;

    integral_scoreboard integrals;

    // Idling percentages for each side, and the receiver's remaining hold-off in cycles.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    // The node positions the stimulus believes are stored; used to keep tables sorted.
    longint shadow_node [ENTRIES];

    // Entry count for each random segment: the nominal extremes, values beyond both ends
    // of the range, and a few in between.
    int count_sweep [SEGMENTS] = '{64, 2, 127, 5, 65, 1, 17, 64, 33, 0};

    partial_trapezoid_integral_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .entry_index   (entry_index),
        .node_position (node_position),
        .node_weight   (node_weight),
        .sample_value  (sample_value),
        .query_point   (query_point),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .integral_out  (integral_out),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // All three channels are observed at the clock edge, before any of the values driven
    // in that step take effect, so every transaction is seen exactly as the unit saw it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                integrals.set_entry_count(cfg_data);
            if (in_valid && in_ready)
                integrals.note_item(opcode, entry_index, node_position, node_weight,
                                    sample_value, query_point);
            if (out_valid && out_ready)
                integrals.check_result(integral_out, status);
        end
    end

    // The result side. A long hold-off, once requested, keeps ready low for that many
    // cycles so that the unit fills up and has to refuse further input transactions.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic longint clamp_node(longint x);
        if (x < NODE_MIN)
            return NODE_MIN;
        if (x > NODE_MAX)
            return NODE_MAX;
        return x;
    endfunction

    function automatic longint draw(longint span);
        return longint'($urandom_range(0, 32'(span)));
    endfunction

    // Mostly modest magnitudes so that sums stay in range, with the full word now and then.
    function automatic logic signed [DW-1:0] rand_sample();
        int unsigned scale;
        scale = $urandom_range(0, 9);
        if (scale < 7)
            return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        if (scale < 9)
            return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        return $urandom;
    endfunction

    // Upper limits: mostly inside the table, some exactly on a node, some just outside it
    // and some anywhere at all.
    function automatic logic signed [DW-1:0] pick_query_point(int eff);
        longint lo;
        longint hi;
        longint tmp;
        int     pick;
        lo = shadow_node[0];
        hi = shadow_node[eff-1];
        if (lo > hi)
        begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return $urandom;
        if (pick < 70)
            tmp = lo + draw(hi - lo);
        else if (pick < 85)
            tmp = shadow_node[$urandom_range(0, eff - 1)];
        else if (pick < 93)
            tmp = lo - 1 - draw(64'sd65536);
        else
            tmp = hi + draw(64'sd65536);
        return DW'(clamp_node(tmp));
    endfunction

    // Offers one item and returns at the edge where it is accepted. Each cycle before the
    // offer is idle with the sender's idling percentage. Valid is lowered only when a gap
    // is taken, so back-to-back items keep it high without a glitch.
    task automatic send_item(input pti_pkg::opcode_t op,
                             input logic [pti_pkg::INDEX_W-1:0] index,
                             input logic signed [DW-1:0] node, weight, value, y);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        entry_index   <= index;
        node_position <= node;
        node_weight   <= weight;
        sample_value  <= value;
        query_point   <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic load_entry(input int index, input longint node,
                              input logic signed [DW-1:0] weight, value);
        shadow_node[index] = node;
        send_item(pti_pkg::OP_LOAD, pti_pkg::INDEX_W'(index), DW'(node), weight, value,
                  $urandom);
    endtask

    // The fields a query does not use carry random bits.
    task automatic run_query(input logic signed [DW-1:0] y);
        send_item(pti_pkg::OP_QUERY, pti_pkg::INDEX_W'($urandom), $urandom, $urandom,
                  $urandom, y);
    endtask

    task automatic write_count(input logic [pti_pkg::COUNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every query has been answered, then lets any load still in progress end.
    task automatic settle();
        in_valid <= 1'b0;
        while (integrals.pending_integrals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A fresh sorted table: a random start, then steps of a random scale, zero included,
    // so that repeated nodes turn up as well as wide grids.
    task automatic load_fresh_table(input int upto);
        longint pos;
        int     shift;
        pos   = longint'($urandom_range(0, 32'hC000_0000)) + NODE_MIN;
        shift = $urandom_range(0, 24);
        for (int i = 0; i < upto; i++)
        begin
            load_entry(i, pos, rand_sample(), rand_sample());
            pos += draw(64'sd1 <<< shift);
        end
    endtask

    // Rewrites one entry, normally between its neighbours so the order survives; now and
    // then anywhere, which breaks the order on purpose.
    task automatic load_random_entry();
        int     index;
        longint lo;
        longint hi;
        longint tmp;
        index = $urandom_range(0, ENTRIES - 1);
        lo = (index == 0) ? clamp_node(shadow_node[1] - 64'sd1048576) : shadow_node[index-1];
        hi = (index == ENTRIES - 1) ? clamp_node(shadow_node[index-1] + 64'sd1048576)
                                    : shadow_node[index+1];
        if ($urandom_range(0, 99) < 15)
        begin
            lo = NODE_MIN;
            hi = NODE_MAX;
        end
        if (lo > hi)
        begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        load_entry(index, lo + draw(hi - lo), rand_sample(), rand_sample());
    endtask

    initial
    begin
        int eff;
        integrals = new();
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        opcode        <= pti_pkg::OP_LOAD;
        entry_index   <= '0;
        node_position <= '0;
        node_weight   <= '0;
        sample_value  <= '0;
        query_point   <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A four-entry table on a unit grid first, then queries on and
        // between its nodes and at both ends of the limit's range.
        write_count(pti_pkg::COUNT_W'(4));
        load_entry(0, 32'sh0000_0000, 32'sh0000_8000, 32'sh0001_0000);
        load_entry(1, 32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000);
        load_entry(2, 32'sh0002_0000, 32'sh0001_0000, 32'sh0003_0000);
        load_entry(3, 32'sh0003_0000, 32'sh0000_8000, 32'sh0004_0000);
        run_query(-32'sd1);
        run_query(32'sh0000_0000);
        run_query(32'sh0001_8000);
        run_query(32'sh0002_0000);
        run_query(32'sh0003_0000);
        run_query(32'sh7FFF_FFFF);
        run_query(32'sh8000_0000);
        // The largest products of either sign drive the sum past both saturation bounds.
        load_entry(3, 32'sh0003_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        run_query(32'sh0004_0000);
        load_entry(3, 32'sh0003_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        run_query(32'sh0004_0000);
        // An out-of-order second node: the scan has to stop on it.
        load_entry(1, 32'sh0005_0000, 32'sh0001_0000, 32'sh8000_0000);
        run_query(32'sh0002_8000);
        run_query(32'sh0003_0000);
        // Nodes at the very ends of the number range give the widest half weights.
        load_entry(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        load_entry(3, 32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh0000_0001);
        run_query(32'sh0000_0000);
        run_query(32'sh7FFF_FFFF);
        settle();
        // Counts below the minimum behave as two entries.
        write_count(pti_pkg::COUNT_W'(0));
        run_query(32'sh0001_0000);
        settle();
        write_count(pti_pkg::COUNT_W'(1));
        run_query(32'sh7FFF_FFFF);
        settle();

        // Random part. Every entry is written before any count can reach it, so no query
        // ever touches an entry that was never loaded.
        load_fresh_table(ENTRIES);
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            settle();
            send_idle_pct = (seg < 4) ? 27 : (seg < 7) ? 77 : 0;
            recv_idle_pct = (seg < 4) ? 77 : (seg < 7) ? 27 : 0;
            write_count(pti_pkg::COUNT_W'(count_sweep[seg]));
            eff = (count_sweep[seg] < 2) ? 2
                : (count_sweep[seg] > ENTRIES) ? ENTRIES : count_sweep[seg];
            // In the first segment the result side stalls for a long stretch while
            // queries keep coming, so the input channel has to back up.
            if (seg == 0)
                hold_left = LONG_HOLD;
            if ($urandom_range(0, 1) == 1)
                load_fresh_table(eff);
            for (int q = 0; q < QUERIES_PER_SEGMENT; q++)
            begin
                while ($urandom_range(0, 99) < 30)
                    load_random_entry();
                run_query(pick_query_point(eff));
            end
        end
        settle();

        $display("Run covered %0d load and %0d query transactions over %0d count settings.",
                 integrals.loads, integrals.queries, integrals.count_writes);
        $display("Expected outcomes: %0d in range, %0d below the first node, %0d saturated.",
                 integrals.status_tally[pti_pkg::STATUS_OK],
                 integrals.status_tally[pti_pkg::STATUS_BELOW],
                 integrals.status_tally[pti_pkg::STATUS_SAT]);
        if (integrals.failures == 0 && integrals.pending_integrals.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // A correct run needs only a small fraction of this time.
    initial
    begin
        #4_000_000;
        $error("watchdog expired with %0d results outstanding",
               integrals.pending_integrals.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
